[rtl/core/i2crtm_pkg.sv]
// ----------------------------------------------------------------------------
// I2C register transaction master - shared definitions
// Phase codes, command codes and the request / result / state records.
// ----------------------------------------------------------------------------
package i2crtm_pkg;

    localparam int C_MAX_BYTES = 6;
    // write_data holds six bytes, so the count never goes beyond that
    localparam logic [2:0] C_CNT_LIMIT = (C_MAX_BYTES < 6) ? 3'(C_MAX_BYTES) : 3'd6;
    localparam logic [7:0] C_AUTO_INC  = 8'h80;
    localparam logic [7:0] C_DELAY_RST = 8'd4;

    typedef enum logic [1:0] {
        CMD_TICK  = 2'd0,
        CMD_READ  = 2'd1,
        CMD_WRITE = 2'd2,
        CMD_NONE  = 2'd3
    } t_cmd;

    typedef enum logic [4:0] {
        PH_IDLE, PH_ST_SDA_LO, PH_ST_WAIT, PH_ST_SCL_LO,
        PH_WB_SDA, PH_WB_SCL_HI, PH_WB_SCL_LO,
        PH_WA_REL, PH_WA_SCL_HI, PH_WA_SCL_LO,
        PH_RS_WAIT, PH_RS_SCL_HI,
        PH_RB_REL, PH_RB_SCL_HI, PH_RB_SCL_LO,
        PH_MA_SDA_LO, PH_MA_SCL_HI, PH_MA_SCL_LO, PH_MA_SDA_HI, PH_MN_SDA_HI,
        PH_SP_SDA_LO, PH_SP_WAIT1, PH_SP_SCL_HI, PH_SP_WAIT2, PH_SP_SDA_HI
    } t_phase;

    typedef struct packed {
        logic [1:0]  command;
        logic [6:0]  device_address;
        logic [6:0]  register_address;
        logic [2:0]  byte_count;
        logic [47:0] write_data;
        logic        sda_in;
    } t_req;

    typedef struct packed {
        logic       scl_out;
        logic       sda_out;
        logic       busy_res;
        logic [7:0] read_byte;
        logic       read_valid;
        logic       read_last;
        logic [7:0] ack_flags;
        logic [3:0] ack_count;
        logic       done_res;
    } t_rsp;

    typedef struct packed {
        t_phase      phase;
        logic [3:0]  bit_cnt;
        logic [2:0]  byte_idx;
        logic [7:0]  shreg;
        logic [7:0]  ack_rec;
        logic [3:0]  ack_tot;
        logic [7:0]  wait_cnt;
        logic [47:0] wbuf;
        logic [6:0]  lat_addr;
        logic [7:0]  lat_reg;
        logic [2:0]  lat_cnt;
        logic        is_read;
        logic        scl;
        logic        sda;
    } t_state;

    localparam t_state C_STATE_RST = '{
        phase:    PH_IDLE,
        bit_cnt:  4'd0,
        byte_idx: 3'd0,
        shreg:    8'd0,
        ack_rec:  8'd0,
        ack_tot:  4'd0,
        wait_cnt: 8'd0,
        wbuf:     48'd0,
        lat_addr: 7'd0,
        lat_reg:  8'd0,
        lat_cnt:  3'd1,
        is_read:  1'b0,
        scl:      1'b1,
        sda:      1'b1
    };

endpackage

[rtl/core/i2crtm_req_if.sv]
// ----------------------------------------------------------------------------
// I2C register transaction master - request channel
// Valid/ready channel carrying one command or tick request.
// ----------------------------------------------------------------------------
interface i2crtm_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  command;
    logic [6:0]  device_address;
    logic [6:0]  register_address;
    logic [2:0]  byte_count;
    logic [47:0] write_data;
    logic        sda_in;

    modport source (
        output valid, command, device_address, register_address,
               byte_count, write_data, sda_in,
        input  ready
    );
    modport sink (
        input  valid, command, device_address, register_address,
               byte_count, write_data, sda_in,
        output ready
    );
endinterface

[rtl/core/i2crtm_rsp_if.sv]
// ----------------------------------------------------------------------------
// I2C register transaction master - result channel
// Valid/ready channel carrying line drive and status for one request.
// ----------------------------------------------------------------------------
interface i2crtm_rsp_if;
    logic       valid;
    logic       ready;
    logic       scl_out;
    logic       sda_out;
    logic       busy_res;
    logic [7:0] read_byte;
    logic       read_valid;
    logic       read_last;
    logic [7:0] ack_flags;
    logic [3:0] ack_count;
    logic       done_res;

    modport source (
        output valid, scl_out, sda_out, busy_res, read_byte, read_valid,
               read_last, ack_flags, ack_count, done_res,
        input  ready
    );
    modport sink (
        input  valid, scl_out, sda_out, busy_res, read_byte, read_valid,
               read_last, ack_flags, ack_count, done_res,
        output ready
    );
endinterface

[rtl/core/i2c_register_transaction_master.sv]
// ----------------------------------------------------------------------------
// I2C register transaction master - top level
// Register read/write transactions on I2C, one bus step per request.
// ----------------------------------------------------------------------------
// Usage:
//   i_req  : one request per bus step. command READ/WRITE starts a transaction
//            when idle (operands latched from the same request); any other
//            request, or a start while busy, is a plain tick. sda_in is the
//            sampled SDA level for that step.
//   o_rsp  : one result per request: SCL/SDA drive, busy, received byte with
//            valid/last flags, acknowledge record and done on STOP.
//   i_cfg_wr_en / i_cfg_wr_data : delay_ticks; the user must write it only while idle (not enforced).
// Path: a request passes the request register, then the step logic into the
//   result register.
// Throughput: one request per cycle unless o_rsp is held; the step logic reads
//   state written on the previous cycle, so back-to-back requests run without bubbles.
// Stall: while o_rsp is held, the request register fills and then i_req.ready
//   drops; nothing is dropped or repeated.
// Reset: lines released, idle, acknowledge record cleared, delay_ticks = 4.
// ----------------------------------------------------------------------------
module i2c_register_transaction_master (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_wr_en,
    input  logic [7:0]         i_cfg_wr_data,
    i2crtm_req_if.sink         i_req,
    i2crtm_rsp_if.source       o_rsp
);
    import i2crtm_pkg::*;

    logic [7:0] r_delay;
    logic       r_in_valid;
    t_req       r_in;
    t_state     r_st;
    t_state     n_st;
    logic       r_out_valid;
    t_rsp       r_out;
    t_rsp       n_out;
    t_req       w_req;
    logic       w_adv;

    assign w_req.command          = i_req.command;
    assign w_req.device_address   = i_req.device_address;
    assign w_req.register_address = i_req.register_address;
    assign w_req.byte_count       = i_req.byte_count;
    assign w_req.write_data       = i_req.write_data;
    assign w_req.sda_in           = i_req.sda_in;

    // the request in the input register moves on when the result slot is free
    assign w_adv       = r_in_valid && (!r_out_valid || o_rsp.ready);
    assign i_req.ready = !r_in_valid || w_adv;

    i2crtm_step u_step (
        .i_state (r_st),
        .i_req   (r_in),
        .i_delay (r_delay),
        .o_next  (n_st),
        .o_rsp   (n_out)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_delay     <= C_DELAY_RST;
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_st        <= C_STATE_RST;
        end else begin
            if (i_cfg_wr_en)
                r_delay <= i_cfg_wr_data;
            if (i_req.ready)
                r_in_valid <= i_req.valid;
            if (w_adv) begin
                r_st        <= n_st;
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.ready && i_req.valid)
            r_in <= w_req;
        if (w_adv)
            r_out <= n_out;
    end

    assign o_rsp.valid      = r_out_valid;
    assign o_rsp.scl_out    = r_out.scl_out;
    assign o_rsp.sda_out    = r_out.sda_out;
    assign o_rsp.busy_res   = r_out.busy_res;
    assign o_rsp.read_byte  = r_out.read_byte;
    assign o_rsp.read_valid = r_out.read_valid;
    assign o_rsp.read_last  = r_out.read_last;
    assign o_rsp.ack_flags  = r_out.ack_flags;
    assign o_rsp.ack_count  = r_out.ack_count;
    assign o_rsp.done_res   = r_out.done_res;

`ifndef SYNTHESIS
    // both lines are released whenever no transaction runs
    a_idle_released: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st.phase == PH_IDLE) |-> (r_st.scl && r_st.sda))
        else $error("bus lines driven while idle");

    // a received byte is only reported while the transaction is still busy
    a_read_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.read_valid) |-> r_out.busy_res)
        else $error("read byte reported outside a transaction");

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.done_res) |-> (!r_out.busy_res && r_out.ack_count <= 4'd8))
        else $error("done reported while still busy");
`endif

endmodule

[rtl/core/i2crtm_step.sv]
// ----------------------------------------------------------------------------
// I2C register transaction master - bus step logic
// Next-state and result for one request against the current controller state.
// ----------------------------------------------------------------------------
module i2crtm_step (
    input  i2crtm_pkg::t_state i_state,
    input  i2crtm_pkg::t_req   i_req,
    input  logic [7:0]         i_delay,
    output i2crtm_pkg::t_state o_next,
    output i2crtm_pkg::t_rsp   o_rsp
);
    import i2crtm_pkg::*;

    // byte to shift out, selected by how many bytes were already acknowledged
    function automatic logic [7:0] f_tx_byte(input t_state st);
        logic [2:0] idx;
        idx = st.ack_tot[2:0] - 3'd2;
        if (st.ack_tot == 4'd0)
            return {st.lat_addr, 1'b0};
        else if (st.ack_tot == 4'd1)
            return st.lat_reg;
        else if (st.is_read)
            return {st.lat_addr, 1'b1};
        else if (!st.ack_tot[3])
            return st.wbuf[{idx, 3'b000} +: 8];
        else
            return 8'd0;
    endfunction

    t_state     s;
    t_cmd       cmd;
    logic [2:0] cnt;
    logic [7:0] rbyte;
    logic       rvalid;
    logic       rlast;
    logic       done;

    always_comb begin
        s      = i_state;
        cmd    = t_cmd'(i_req.command);
        cnt    = i_req.byte_count;
        rbyte  = 8'd0;
        rvalid = 1'b0;
        rlast  = 1'b0;
        done   = 1'b0;

        if (cnt == 3'd0)
            cnt = 3'd1;
        if (cnt > C_CNT_LIMIT)
            cnt = C_CNT_LIMIT;

        if (s.phase == PH_IDLE && (cmd == CMD_READ || cmd == CMD_WRITE)) begin
            s.lat_cnt  = cnt;
            s.lat_addr = i_req.device_address;
            s.lat_reg  = {1'b0, i_req.register_address} | ((cnt > 3'd1) ? C_AUTO_INC : 8'd0);
            s.wbuf     = i_req.write_data;
            s.is_read  = (cmd == CMD_READ);
            s.ack_rec  = 8'd0;
            s.ack_tot  = 4'd0;
            s.byte_idx = 3'd0;
            s.bit_cnt  = 4'd0;
            s.shreg    = 8'd0;
            s.phase    = PH_ST_SDA_LO;
        end

        case (s.phase)
            PH_IDLE: begin
            end
            PH_ST_SDA_LO: begin
                s.sda = 1'b0;
                if (i_delay == 8'd0) begin
                    s.phase = PH_ST_SCL_LO;
                end else begin
                    s.phase    = PH_ST_WAIT;
                    s.wait_cnt = i_delay;
                end
            end
            PH_ST_SCL_LO: begin
                s.scl     = 1'b0;
                s.shreg   = f_tx_byte(s);
                s.bit_cnt = 4'd0;
                s.phase   = PH_WB_SDA;
            end
            PH_WB_SDA: begin
                s.sda   = s.shreg[7];
                s.phase = PH_WB_SCL_HI;
            end
            PH_WB_SCL_HI: begin
                s.scl   = 1'b1;
                s.phase = PH_WB_SCL_LO;
            end
            PH_WB_SCL_LO: begin
                s.scl     = 1'b0;
                s.shreg   = {s.shreg[6:0], 1'b0};
                s.bit_cnt = s.bit_cnt + 4'd1;
                s.phase   = (s.bit_cnt >= 4'd8) ? PH_WA_REL : PH_WB_SDA;
            end
            PH_WA_REL: begin
                s.sda   = 1'b1;
                s.phase = PH_WA_SCL_HI;
            end
            PH_WA_SCL_HI: begin
                s.scl = 1'b1;
                if (s.ack_tot < 4'd8) begin
                    if (i_req.sda_in)
                        s.ack_rec[s.ack_tot[2:0]] = 1'b1;
                    s.ack_tot = s.ack_tot + 4'd1;
                end
                s.phase = PH_WA_SCL_LO;
            end
            PH_WA_SCL_LO: begin
                s.scl = 1'b0;
                if (s.is_read) begin
                    if (s.ack_tot == 4'd1) begin
                        s.shreg   = f_tx_byte(s);
                        s.bit_cnt = 4'd0;
                        s.phase   = PH_WB_SDA;
                    end else if (s.ack_tot == 4'd2) begin
                        if (i_delay == 8'd0) begin
                            s.phase = PH_RS_SCL_HI;
                        end else begin
                            s.phase    = PH_RS_WAIT;
                            s.wait_cnt = i_delay;
                        end
                    end else begin
                        s.byte_idx = 3'd0;
                        s.bit_cnt  = 4'd0;
                        s.shreg    = 8'd0;
                        s.phase    = PH_RB_REL;
                    end
                end else if (s.ack_tot < ({1'b0, s.lat_cnt} + 4'd2)) begin
                    s.shreg   = f_tx_byte(s);
                    s.bit_cnt = 4'd0;
                    s.phase   = PH_WB_SDA;
                end else begin
                    s.phase = PH_SP_SDA_LO;
                end
            end
            PH_RS_SCL_HI: begin
                s.scl   = 1'b1;
                s.phase = PH_ST_SDA_LO;
            end
            PH_RB_REL: begin
                s.sda   = 1'b1;
                s.phase = PH_RB_SCL_HI;
            end
            PH_RB_SCL_HI: begin
                s.scl   = 1'b1;
                s.shreg = {s.shreg[6:0], i_req.sda_in};
                s.phase = PH_RB_SCL_LO;
            end
            PH_RB_SCL_LO: begin
                s.scl     = 1'b0;
                s.bit_cnt = s.bit_cnt + 4'd1;
                if (s.bit_cnt >= 4'd8) begin
                    rvalid     = 1'b1;
                    rbyte      = s.shreg;
                    s.byte_idx = s.byte_idx + 3'd1;
                    rlast      = (s.byte_idx >= s.lat_cnt);
                    s.phase    = rlast ? PH_MN_SDA_HI : PH_MA_SDA_LO;
                end else begin
                    s.phase = PH_RB_REL;
                end
            end
            PH_MA_SDA_LO: begin
                s.sda   = 1'b0;
                s.phase = PH_MA_SCL_HI;
            end
            PH_MA_SCL_HI: begin
                s.scl   = 1'b1;
                s.phase = PH_MA_SCL_LO;
            end
            PH_MA_SCL_LO: begin
                s.scl   = 1'b0;
                s.phase = PH_MA_SDA_HI;
            end
            PH_MA_SDA_HI: begin
                s.sda     = 1'b1;
                s.bit_cnt = 4'd0;
                s.shreg   = 8'd0;
                s.phase   = PH_RB_REL;
            end
            PH_MN_SDA_HI: begin
                s.sda   = 1'b1;
                s.phase = PH_SP_SDA_LO;
            end
            PH_SP_SDA_LO: begin
                s.sda = 1'b0;
                if (i_delay == 8'd0) begin
                    s.phase = PH_SP_SCL_HI;
                end else begin
                    s.phase    = PH_SP_WAIT1;
                    s.wait_cnt = i_delay;
                end
            end
            PH_SP_SCL_HI: begin
                s.scl = 1'b1;
                if (i_delay == 8'd0) begin
                    s.phase = PH_SP_SDA_HI;
                end else begin
                    s.phase    = PH_SP_WAIT2;
                    s.wait_cnt = i_delay;
                end
            end
            PH_SP_SDA_HI: begin
                s.sda   = 1'b1;
                s.phase = PH_IDLE;
                done    = 1'b1;
            end
            PH_ST_WAIT, PH_RS_WAIT, PH_SP_WAIT1, PH_SP_WAIT2: begin
                if (s.wait_cnt != 8'd0)
                    s.wait_cnt = s.wait_cnt - 8'd1;
                if (s.wait_cnt == 8'd0) begin
                    case (s.phase)
                        PH_ST_WAIT:  s.phase = PH_ST_SCL_LO;
                        PH_RS_WAIT:  s.phase = PH_RS_SCL_HI;
                        PH_SP_WAIT1: s.phase = PH_SP_SCL_HI;
                        default:     s.phase = PH_SP_SDA_HI;
                    endcase
                end
            end
            default: begin
                s.phase = PH_IDLE;
            end
        endcase

        o_next             = s;
        o_rsp.scl_out      = s.scl;
        o_rsp.sda_out      = s.sda;
        o_rsp.busy_res     = (s.phase != PH_IDLE);
        o_rsp.read_byte    = rbyte;
        o_rsp.read_valid   = rvalid;
        o_rsp.read_last    = rlast;
        o_rsp.ack_flags    = s.ack_rec;
        o_rsp.ack_count    = s.ack_tot;
        o_rsp.done_res     = done;
    end

endmodule
